// ===== sv/cc20_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers of the ChaCha20 byte stream XOR block.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int BLOCK_BYTES       = 64;
  localparam int POS_W             = 7;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;

  localparam logic [31:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  localparam logic [63:0] KEY_RST        = 64'h0;
  localparam logic [63:0] NONCE_LOW_RST  = 64'h0;
  localparam logic [31:0] NONCE_HIGH_RST = 32'h01000000;
  localparam logic [31:0] INIT_CTR_RST   = 32'h00000001;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_0,
    REG_KEY_1,
    REG_KEY_2,
    REG_KEY_3,
    REG_NONCE_LOW,
    REG_NONCE_HIGH,
    REG_INIT_CTR
  } cc20_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } cc20_state_t;

  typedef struct packed {
    logic       start;
    logic       emit_now;
    logic       step;
    logic [1:0] sub;
    logic       diag;
    logic       finish;
    logic       emit_held;
  } cc20_cmd_t;

  typedef struct packed {
    logic need_block;
    logic out_free;
  } cc20_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

// ===== sv/cc20_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_if
// Valid/ready channels of the ChaCha20 block: input bytes, output bytes and
// register writes.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       last_in_message;

  modport source (output valid, output data_in, output last_in_message, input ready);
  modport sink   (input valid, input data_in, input last_in_message, output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;

  modport source (output valid, output data_out, output last_out, input ready);
  modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

interface cc20_cfg_if
  import cc20_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/cc20_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts bytes, runs the round steps of a new block and orders
// the feed-forward and the delayed transfer of the byte that opened it.
// ----------------------------------------------------------------------------
module cc20_ctrl
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  cc20_status_t status,
  output cc20_cmd_t    cmd
);

  localparam int STEPS = DOUBLE_ROUNDS * 8;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  cc20_state_t      state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_ROUND) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && status.need_block) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt == CNT_LAST) state_next = ST_FEED;
      end
      ST_FEED: state_next = ST_EMIT;
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.sub       = cnt[1:0];
    cmd.diag      = cnt[2];
    case (state)
      ST_IDLE: begin
        in_ready     = status.out_free;
        cmd.start    = accept && status.need_block;
        cmd.emit_now = accept && !status.need_block;
      end
      ST_ROUND: cmd.step      = 1'b1;
      ST_FEED:  cmd.finish    = 1'b1;
      ST_EMIT:  cmd.emit_held = 1'b1;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  a_start_round: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_ROUND) && (cnt == '0))
    else $error("block start did not enter round steps");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && cnt == CNT_LAST) |=> state == ST_FEED)
    else $error("round steps did not end in feed-forward");

  a_feed_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEED) |=> (state == ST_EMIT) && !in_ready)
    else $error("feed-forward not followed by held byte transfer");

endmodule

// ===== sv/cc20_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_dp
// Datapath: config registers, working state with four quarter-round lanes,
// keystream buffer, block counter, byte position and output register.
// ----------------------------------------------------------------------------
module cc20_dp
  import cc20_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  cc20_cfg_if.sink     cfg,
  input  logic [7:0]   data_in,
  input  logic         last_in_message,
  cc20_out_if.source   dout,
  input  cc20_cmd_t    cmd,
  output cc20_status_t status
);

  logic [63:0] key_0, key_1, key_2, key_3, nonce_low;
  logic [31:0] nonce_high, initial_counter;

  logic [31:0] work [16];
  logic [31:0] work_next [16];
  logic [31:0] ks [16];
  logic [31:0] init_w [16];
  logic [31:0] ctr, ctr_sel;
  logic [POS_W-1:0] pos;
  logic        in_message;
  logic [7:0]  held_data;
  logic        held_last;
  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_last;

  logic        emit;
  logic [7:0]  emit_data;
  logic        emit_last;
  logic [31:0] ks_word;
  logic [31:0] ks_shift;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0           <= KEY_RST;
      key_1           <= KEY_RST;
      key_2           <= KEY_RST;
      key_3           <= KEY_RST;
      nonce_low       <= NONCE_LOW_RST;
      nonce_high      <= NONCE_HIGH_RST;
      initial_counter <= INIT_CTR_RST;
    end else if (cfg.valid) begin
      case (cc20_reg_t'(cfg.index))
        REG_KEY_0:      key_0           <= cfg.data;
        REG_KEY_1:      key_1           <= cfg.data;
        REG_KEY_2:      key_2           <= cfg.data;
        REG_KEY_3:      key_3           <= cfg.data;
        REG_NONCE_LOW:  nonce_low       <= cfg.data;
        REG_NONCE_HIGH: nonce_high      <= cfg.data[31:0];
        REG_INIT_CTR:   initial_counter <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  assign ctr_sel = in_message ? ctr : initial_counter;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i] = SIGMA[i];
    end
    init_w[4]  = key_0[31:0];
    init_w[5]  = key_0[63:32];
    init_w[6]  = key_1[31:0];
    init_w[7]  = key_1[63:32];
    init_w[8]  = key_2[31:0];
    init_w[9]  = key_2[63:32];
    init_w[10] = key_3[31:0];
    init_w[11] = key_3[63:32];
    init_w[12] = ctr_sel;
    init_w[13] = nonce_low[31:0];
    init_w[14] = nonce_low[63:32];
    init_w[15] = nonce_high;
  end

  // one add-xor-rotate step of four quarter-rounds in parallel
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] mix;
    work_next = work;
    for (int j = 0; j < 4; j++) begin
      ia = {2'b00, 2'(j)};
      ib = {2'b01, 2'(j) + {1'b0, cmd.diag}};
      ic = {2'b10, 2'(j) + {cmd.diag, 1'b0}};
      id = {2'b11, 2'(j) + {cmd.diag, cmd.diag}};
      case (cmd.sub)
        2'd0: begin
          mix           = work[ia] + work[ib];
          work_next[ia] = mix;
          work_next[id] = rotl(work[id] ^ mix, 16);
        end
        2'd1: begin
          mix           = work[ic] + work[id];
          work_next[ic] = mix;
          work_next[ib] = rotl(work[ib] ^ mix, 12);
        end
        2'd2: begin
          mix           = work[ia] + work[ib];
          work_next[ia] = mix;
          work_next[id] = rotl(work[id] ^ mix, 8);
        end
        default: begin
          mix           = work[ic] + work[id];
          work_next[ic] = mix;
          work_next[ib] = rotl(work[ib] ^ mix, 7);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      work <= init_w;
    end else if (cmd.step) begin
      work <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        ks[i] <= work[i] + init_w[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      held_data <= data_in;
      held_last <= last_in_message;
    end
  end

  assign emit      = cmd.emit_now || cmd.emit_held;
  assign emit_data = cmd.emit_held ? held_data : data_in;
  assign emit_last = cmd.emit_held ? held_last : last_in_message;
  assign ks_word   = ks[pos[5:2]];
  assign ks_shift  = ks_word >> {pos[1:0], 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr        <= INIT_CTR_RST;
      pos        <= POS_W'(BLOCK_BYTES);
      in_message <= 1'b0;
    end else begin
      if (cmd.start) begin
        ctr        <= ctr_sel;
        in_message <= 1'b1;
      end else if (cmd.finish) begin
        ctr <= ctr + 1'b1;
        pos <= '0;
      end else if (emit) begin
        pos        <= pos + 1'b1;
        in_message <= !emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data ^ ks_shift[7:0];
      out_last <= emit_last;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.data_out  = out_data;
  assign dout.last_out  = out_last;

  assign status.need_block = !in_message || (pos == POS_W'(BLOCK_BYTES));
  assign status.out_free   = !out_valid || dout.ready;

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> status.out_free)
    else $error("byte transfer overwrote a pending result");

  a_finish_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (pos == '0) && in_message && (ctr == $past(ctr) + 32'd1))
    else $error("new block did not reset position or advance counter");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> !in_message && status.need_block)
    else $error("last byte did not close the message");

endmodule

// ===== sv/chacha20_stream_xor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 (IETF) stream cipher, one byte per transfer XORed with keystream.
// ----------------------------------------------------------------------------
//   channel     dir  payload                          handshake
//   stream_in   in   data_in[7:0], last_in_message    valid/ready
//   stream_out  out  data_out[7:0], last_out          valid/ready
//   cfg         in   index[2:0], data[63:0]           valid/ready (ready = 1)
//
// A byte inside a buffered keystream block is accepted every cycle while the
// output register is free, and its result is valid on the next cycle.
// A byte that opens a block is handled in order by one load, 8*DOUBLE_ROUNDS
// add-xor-rotate steps of the four shared quarter-round lanes, one feed-forward
// add and one output transfer; no new input is accepted until these are done,
// and the output transfer writes its result to the output register.
// Reset (synchronous) closes any open message; the next byte starts a block
// at initial_counter. A stalled output blocks new input.
// ----------------------------------------------------------------------------
module chacha20_stream_xor
  import cc20_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cc20_cfg_if.sink    cfg,
  cc20_in_if.sink     stream_in,
  cc20_out_if.source  stream_out
);

  cc20_cmd_t    cmd;
  cc20_status_t status;
  logic         in_ready;

  assign stream_in.ready = in_ready;

  cc20_ctrl #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cc20_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .data_in         (stream_in.data_in),
    .last_in_message (stream_in.last_in_message),
    .dout            (stream_out),
    .cmd             (cmd),
    .status          (status)
  );

endmodule
